FILE: design/cellular_automaton_additive_synth_top_macros.svh
// Assertion macros shared by the cellular automaton synth RTL.
`ifndef CELLULAR_AUTOMATON_ADDITIVE_SYNTH_TOP_MACROS_SVH
`define CELLULAR_AUTOMATON_ADDITIVE_SYNTH_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CAAS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CAAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/caas_pkg.sv
// Types, constants and sine table builder for the cellular automaton synth.
package caas_pkg;

  localparam int CELLS_DEF = 256;
  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int SINE_MAX = 4096;
  localparam int SINE_MAX_LG = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int AMPLITUDE = 100;

  localparam logic [CFG_IDX_W-1:0] REG_RULE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FSTEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PSTEP = 3'd4;

  localparam logic [7:0] RULE_RST = 8'd110;
  localparam logic [8:0] CELLS_RST = 9'd200;
  localparam logic [15:0] SPG_RST = 16'd705;
  localparam logic [15:0] FSTEP_RST = 16'd25600;
  localparam logic [23:0] PSTEP_RST = 24'd97392;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] cell_index;
    logic       cell_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [15:0]        generation;
  } out_t;

  // Partial-unit status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic valid;
    logic live;
  } pt_stat_t;

  // Each entry holds trunc(100 * sin / 32768) directly.
  typedef logic [SINE_MAX-1:0][7:0] sine_tab_t;

  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] th;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    th = (u * PI_Q30) >> 31;
    sum = th;
    term = th;
    for (int n = 1; n <= 5; n++) begin
      term = (((term * th) >> 30) * th) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v;
  endfunction

  function automatic sine_tab_t build_sine(input int lg);
    sine_tab_t   tab;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] f;
    logic [63:0] u;
    logic [63:0] m;
    logic [63:0] c;
    tab = '0;
    for (int k = 0; k < (1 << lg); k++) begin
      t = 64'(k) << (32 - lg);
      q = (t >> 30) & 64'd3;
      f = t & ((64'd1 << 30) - 64'd1);
      u = q[0] ? (64'd1 << 30) - f : f;
      m = quarter_sine(u);
      c = (m * 64'(AMPLITUDE)) >> 15;
      tab[k] = (q >= 64'd2) ? 8'(-c) : 8'(c);
    end
    return tab;
  endfunction

endpackage

FILE: design/caas_partial.sv
// Pipelined partial unit: cell index to signed sine contribution.
module caas_partial #(
  parameter int CELLS = caas_pkg::CELLS_DEF,
  parameter int SINE_ENTRIES = caas_pkg::SINE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_v,
  input  logic                       in_live,
  input  logic [$clog2(CELLS+2)-1:0] in_x,
  input  logic [31:0]                sample_idx,
  input  logic [15:0]                freq_step,
  input  logic [23:0]                phase_step,
  output caas_pkg::pt_stat_t         stat,
  output logic [7:0]                 contrib
);

  localparam int CW = $clog2(CELLS + 2);
  localparam int FW = 16 + CW - 8;
  localparam int LG = $clog2(SINE_ENTRIES);
  localparam caas_pkg::sine_tab_t SINE_TAB = caas_pkg::build_sine(LG);

  logic          v1_r, v2_r, v3_r, v4_r;
  logic          l1_r, l2_r, l3_r, l4_r;
  logic [FW-1:0] freq_r;
  logic [31:0]   p1_r;
  logic [31:0]   p2_r;
  logic [7:0]    rom_r;
  logic [15+CW:0] fprod;

  assign fprod = {{CW{1'b0}}, freq_step} * {16'd0, in_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    l1_r   <= in_live;
    l2_r   <= l1_r;
    l3_r   <= l2_r;
    l4_r   <= l3_r;
    freq_r <= fprod[15+CW:8];
    p1_r   <= 32'(sample_idx * 32'(freq_r));
    p2_r   <= 32'(p1_r * {8'd0, phase_step});
    rom_r  <= SINE_TAB[caas_pkg::SINE_MAX_LG'(p2_r[31 -: LG])];
  end

  assign stat.busy  = v1_r | v2_r | v3_r;
  assign stat.valid = v4_r;
  assign stat.live  = l4_r;
  assign contrib    = rom_r;

endmodule

FILE: design/cellular_automaton_additive_synth_top.sv
// Top level of the cellular automaton additive synth voice.
//
// Input channel (in_valid/in_stall/in_data): opcode 0 writes one seed cell
// and restarts sample, tick and generation counters; opcode 1 asks for one
// sample. Output channel (out_valid/out_stall/out_data) carries one sample
// and its generation number per tick transaction; seeds give nothing.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes a register; write it
// only while the block is idle.
// A seed is written directly in idle. A tick reads one row memory cell per
// cycle for the n active cells, feeding the partial pipeline (freq, p1,
// p2, rom), then the finish state. When a generation ends, the row update
// walks the memory once more, reading ahead and writing behind.
// The result sits in an output register; while the receiver stalls, the
// block still takes seed transactions but holds a finished tick in its
// finish state until the register frees.
// Reset is synchronous; afterward a clearing pass zeroes the row memory,
// during which in_stall stays high (config writes still work).
module cellular_automaton_additive_synth_top #(
  parameter int CELLS = caas_pkg::CELLS_DEF,
  parameter int SINE_ENTRIES = caas_pkg::SINE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  caas_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output caas_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [caas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [caas_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  `include "cellular_automaton_additive_synth_top_macros.svh"

  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + 2);
  localparam int ACC_W = $clog2(CELLS * caas_pkg::AMPLITUDE + 1) + 2;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_ADV  = 3'd4;

  logic [2:0]  st_r;
  logic [7:0]  rule_r;
  logic [8:0]  cells_r;
  logic [15:0] spg_r;
  logic [15:0] fstep_r;
  logic [23:0] pstep_r;

  logic [31:0] sample_idx_r;
  logic [15:0] ticks_r;
  logic [15:0] gen_r;

  logic        mem [CELLS];
  logic        rd_data_r;
  logic [AW-1:0] rd_addr;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic        mem_wd;

  logic [AW-1:0] clr_cnt_r;
  logic [CW-1:0] n_act;
  logic [CW-1:0] x_cnt_r;
  logic [CW-1:0] x0_r;
  logic          v0_r;
  logic          iss;
  logic signed [ACC_W-1:0] acc_r;

  logic [CW-1:0] a_cnt_r;
  logic [CW-1:0] a_idx_r;
  logic          a_v_r;
  logic          a_iss;
  logic          a_left_r;
  logic          a_cur_r;
  logic          a_dm;
  logic [2:0]    a_nb;

  logic          in_acc;
  logic          fin_go;
  logic [15:0]   ticks_inc;
  logic signed [15:0] sat_sum;

  caas_pkg::pt_stat_t pt_stat;
  logic [7:0]         pt_contrib;
  caas_pkg::out_t     out_r;
  logic               out_valid_r;

  assign in_stall  = (st_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fin_go    = !out_valid_r || !out_stall;
  assign ticks_inc = ticks_r + 16'd1;

  always_comb begin
    if (32'(cells_r) < 32'(CELLS)) begin
      n_act = CW'(cells_r);
    end else begin
      n_act = CW'(CELLS);
    end
  end

  assign iss   = (st_r == ST_SUM) && (x_cnt_r < n_act);
  assign a_iss = (st_r == ST_ADV) && (a_cnt_r <= n_act);
  assign a_dm  = (a_idx_r < n_act) ? rd_data_r : 1'b0;
  assign a_nb  = {a_left_r, a_cur_r, a_dm};

  always_comb begin
    if (ACC_W'(acc_r) > ACC_W'(32767)) begin
      sat_sum = 16'sd32767;
    end else if (acc_r < -ACC_W'(32768)) begin
      sat_sum = -16'sd32768;
    end else begin
      sat_sum = acc_r[15:0];
    end
  end

  // Row memory port selection.
  always_comb begin
    rd_addr = (st_r == ST_ADV) ? a_cnt_r[AW-1:0] : x_cnt_r[AW-1:0];
    mem_we  = 1'b0;
    mem_wa  = clr_cnt_r;
    mem_wd  = 1'b0;
    if (st_r == ST_CLR) begin
      mem_we = 1'b1;
    end else if (in_acc && in_data.opcode == caas_pkg::OP_SEED) begin
      mem_we = (32'(in_data.cell_index) < 32'(CELLS));
      mem_wa = AW'(in_data.cell_index);
      mem_wd = in_data.cell_value;
    end else if (st_r == ST_ADV && a_v_r && a_idx_r != '0) begin
      // write behind: cell a_idx-1 with its old neighbors
      mem_we = 1'b1;
      mem_wa = AW'(a_idx_r - CW'(1));
      mem_wd = rule_r[a_nb];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r  <= caas_pkg::RULE_RST;
      cells_r <= caas_pkg::CELLS_RST;
      spg_r   <= caas_pkg::SPG_RST;
      fstep_r <= caas_pkg::FSTEP_RST;
      pstep_r <= caas_pkg::PSTEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        caas_pkg::REG_RULE:  rule_r  <= cfg_wdata[7:0];
        caas_pkg::REG_CELLS: cells_r <= cfg_wdata[8:0];
        caas_pkg::REG_SPG:   spg_r   <= cfg_wdata[15:0];
        caas_pkg::REG_FSTEP: fstep_r <= cfg_wdata[15:0];
        caas_pkg::REG_PSTEP: pstep_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  caas_partial #(
    .CELLS(CELLS),
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_partial (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (v0_r),
    .in_live    (rd_data_r),
    .in_x       (x0_r),
    .sample_idx (sample_idx_r),
    .freq_step  (fstep_r),
    .phase_step (pstep_r),
    .stat       (pt_stat),
    .contrib    (pt_contrib)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLR;
      clr_cnt_r    <= '0;
      sample_idx_r <= '0;
      ticks_r      <= '0;
      gen_r        <= '0;
      out_valid_r  <= 1'b0;
      v0_r         <= 1'b0;
      a_v_r        <= 1'b0;
      x_cnt_r      <= '0;
      a_cnt_r      <= '0;
    end else begin
      // in the finish state the handoff below decides out_valid_r
      if (out_valid_r && !out_stall && st_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      v0_r  <= iss;
      a_v_r <= a_iss;
      unique case (st_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(CELLS - 1)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.opcode == caas_pkg::OP_SEED) begin
              sample_idx_r <= '0;
              ticks_r      <= '0;
              gen_r        <= '0;
            end else begin
              x_cnt_r <= '0;
              st_r    <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (iss) begin
            x_cnt_r <= x_cnt_r + CW'(1);
          end else if (!v0_r && !pt_stat.busy && !pt_stat.valid) begin
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_r  <= 1'b1;
            sample_idx_r <= sample_idx_r + 32'd1;
            if (ticks_inc >= spg_r) begin
              ticks_r <= '0;
              gen_r   <= gen_r + 16'd1;
              a_cnt_r <= '0;
              st_r    <= (n_act != '0) ? ST_ADV : ST_IDLE;
            end else begin
              ticks_r <= ticks_inc;
              st_r    <= ST_IDLE;
            end
          end
        end
        ST_ADV: begin
          if (a_iss) begin
            a_cnt_r <= a_cnt_r + CW'(1);
          end
          if (a_v_r && a_idx_r == n_act) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    x0_r    <= x_cnt_r;
    a_idx_r <= a_cnt_r;
    if (st_r == ST_IDLE) begin
      acc_r <= '0;
    end else if (pt_stat.valid && pt_stat.live) begin
      acc_r <= acc_r + {{(ACC_W-8){pt_contrib[7]}}, pt_contrib};
    end
    if (a_v_r) begin
      a_left_r <= (a_idx_r == '0) ? 1'b0 : a_cur_r;
      a_cur_r  <= a_dm;
    end
    if (st_r == ST_FIN && fin_go) begin
      out_r.sample     <= sat_sum;
      out_r.generation <= gen_r;
    end
  end

  `CAAS_ASSERT_NXT(a_out_from_fin, !out_valid_r, !out_valid_r || $past(st_r == ST_FIN), "result appeared outside finish")
  `CAAS_ASSERT(a_no_write_in_sum, st_r == ST_SUM, !mem_we, "row memory written during sample pass")
  `CAAS_ASSERT_NXT(a_idx_step, st_r == ST_FIN && fin_go, sample_idx_r == $past(sample_idx_r) + 32'd1, "sample index did not advance")

endmodule
